FILE: hdl/dtfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtfc_pkg
// Types, constants and field coding functions of the dead-time field codec.
// ----------------------------------------------------------------------------
package dtfc_pkg;

	localparam int NS_W    = 16;
	localparam int CLK_W   = 29;
	localparam int CODE_W  = 8;
	localparam int TICK_W  = 11;  // tick count, clamped at 1024
	localparam int DTK_W   = 10;  // decoded ticks, at most 1008
	localparam int PROD_W  = 46;  // ns * clk + half second
	localparam int NUM_W   = 40;  // remainders and decoded numerator
	localparam int CMP_W   = 45;  // clock shifted by up to 16 places
	localparam int BQ_W    = 16;  // quotient bits of the nanosecond division

	// One second in ns is 2^9 * 1953125. The tick division drops the power of
	// two by a shift and divides the rest by a reciprocal multiplication.
	localparam int TICK_SH = 9;
	localparam int DIVN_W  = 31;  // shifted sum below the saturation limit
	localparam int RCP_W   = 32;
	localparam int RPROD_W = 63;
	localparam int RCP_SH  = 52;
	// ceil(2^52 / 1953125); exact for every operand below 2^31.
	localparam logic [RCP_W-1:0]  RCP_M         = 32'd2305843010;

	localparam logic [CLK_W-1:0]  CLK_RESET     = 29'd170000000;
	localparam logic [NUM_W-1:0]  NS_PER_S      = 40'd1000000000;
	localparam logic [PROD_W-1:0] HALF_NS_PER_S = 46'd500000000;
	// Products at or above this many ns*Hz give 1024 ticks or more.
	localparam logic [PROD_W-1:0] TICK_LIMIT    = 46'd1024000000000;
	localparam logic [BQ_W-1:0]   NS_MAX        = 16'hFFFF;
	localparam logic [CODE_W-1:0] CODE_MAX      = 8'hFF;

	// Piecewise field: step 1, 2, 8 and 16 ticks.
	function automatic logic [CODE_W-1:0] encode_ticks(input logic [TICK_W-1:0] t);
		logic [CODE_W-1:0] c;
		if (t <= 11'd127) begin
			c = t[7:0];
		end else if (t <= 11'd255) begin
			c = {2'b10, t[6:1]};
		end else if (t <= 11'd511) begin
			c = {3'b110, t[7:3]};
		end else if (t[10]) begin
			c = CODE_MAX;
		end else begin
			c = {3'b111, t[8:4]};
		end
		return c;
	endfunction

	function automatic logic [DTK_W-1:0] decode_ticks(input logic [CODE_W-1:0] c);
		logic [DTK_W-1:0] t;
		if (!c[7]) begin
			t = {3'b000, c[6:0]};
		end else if (!c[6]) begin
			t = {3'b001, c[5:0], 1'b0};
		end else if (!c[5]) begin
			t = {2'b01, c[4:0], 3'b000};
		end else begin
			t = {1'b1, c[4:0], 4'b0000};
		end
		return t;
	endfunction

endpackage

FILE: hdl/dead_time_field_codec.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dead_time_field_codec
// Converts a requested dead time in ns to the 8-bit dead-time field and back.
// ----------------------------------------------------------------------------
// Usage: the in channel carries request_ns, the requested dead time in ns; the
// out channel returns one item per input with dtg_code and actual_dead_time_ns.
// The cfg channel writes timer_clock_hz and is always ready; write it only
// while no item is in flight.
// The tick count is ns * clk / 1e9 rounded to nearest. The division by 1e9 is
// a shift by nine places followed by a multiplication with the reciprocal of
// 1953125. The code is decoded back and divided by the clock in a pipelined
// restoring divider of sixteen stages, one quotient bit per stage.
// One item can enter every cycle while the receiver does not stall, so the
// sustained rate is one item per cycle.
// The whole pipeline advances together whenever the output register is empty
// or being taken; while the receiver stalls, in_ready is low and every stage
// holds its item, so nothing is lost or repeated.
// Reset clears all valid bits and sets timer_clock_hz to 170 MHz.
// ----------------------------------------------------------------------------
module dead_time_field_codec (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dtfc_pkg::CLK_W-1:0]    timer_clock_hz,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [dtfc_pkg::NS_W-1:0]     request_ns,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dtfc_pkg::CODE_W-1:0]   dtg_code,
	output logic [dtfc_pkg::NS_W-1:0]     actual_dead_time_ns
);

	localparam int BN = dtfc_pkg::BQ_W;

	logic [dtfc_pkg::CLK_W-1:0] clk_hz_q;
	logic adv;

	logic                         v_s1;
	logic [dtfc_pkg::NS_W-1:0]    ns_s1;
	logic                         v_s2;
	logic [dtfc_pkg::PROD_W-1:0]  x_s2;

	// Tick division stages.
	logic                         v_s3;
	logic                         sat_s3;
	logic [dtfc_pkg::DIVN_W-1:0]  n_s3;
	logic                         v_s4;
	logic                         sat_s4;
	logic [dtfc_pkg::RPROD_W-1:0] prod_s4;

	logic                         v_s5;
	logic [dtfc_pkg::CODE_W-1:0]  code_s5;
	logic [dtfc_pkg::DTK_W-1:0]   dtk_s5;
	logic                         v_s6;
	logic [dtfc_pkg::CODE_W-1:0]  code_s6;
	logic [dtfc_pkg::NUM_W-1:0]   num_s6;

	// Nanosecond divider stages.
	logic                         b_v_s    [0:BN];
	logic                         b_sat_s  [0:BN];
	logic                         b_zero_s [0:BN];
	logic [dtfc_pkg::CODE_W-1:0]  b_code_s [0:BN];
	logic [dtfc_pkg::NUM_W-1:0]   b_rem_s  [0:BN];
	logic [BN-1:0]                b_q_s    [0:BN];

	logic [dtfc_pkg::TICK_W-1:0]  ticks;
	logic [dtfc_pkg::CMP_W-1:0]   clk_sat_lim;

	assign adv       = !out_valid || out_ready;
	assign in_ready  = adv;
	assign cfg_ready = 1'b1;

	assign ticks = sat_s4 ? 11'd1024
		: prod_s4[dtfc_pkg::RCP_SH+dtfc_pkg::TICK_W-1:dtfc_pkg::RCP_SH];
	assign clk_sat_lim = {clk_hz_q, 16'h0000};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clk_hz_q <= dtfc_pkg::CLK_RESET;
		end else if (cfg_valid) begin
			clk_hz_q <= timer_clock_hz;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			out_valid <= 1'b0;
			for (int k = 0; k <= BN; k++) b_v_s[k] <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			b_v_s[0] <= v_s6;
			for (int k = 0; k < BN; k++) b_v_s[k+1] <= b_v_s[k];
			out_valid <= b_v_s[BN];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ns_s1 <= request_ns;
			x_s2  <= dtfc_pkg::PROD_W'({16'h0000, clk_hz_q} * {29'h0, ns_s1})
				+ dtfc_pkg::HALF_NS_PER_S;

			// Above the limit the shifted sum is not used.
			sat_s3 <= x_s2 >= dtfc_pkg::TICK_LIMIT;
			n_s3   <= x_s2[dtfc_pkg::NUM_W-1:dtfc_pkg::TICK_SH];

			sat_s4  <= sat_s3;
			prod_s4 <= {32'h0, n_s3} * {31'h0, dtfc_pkg::RCP_M};

			code_s5 <= dtfc_pkg::encode_ticks(ticks);
			dtk_s5  <= dtfc_pkg::decode_ticks(dtfc_pkg::encode_ticks(ticks));

			code_s6 <= code_s5;
			num_s6  <= dtfc_pkg::NUM_W'({30'h0, dtk_s5} * dtfc_pkg::NS_PER_S)
				+ {12'h000, clk_hz_q[dtfc_pkg::CLK_W-1:1]};

			// A quotient of 65536 or more saturates; a zero clock gives zero.
			b_zero_s[0] <= clk_hz_q == '0;
			b_sat_s[0]  <= {5'h00, num_s6} >= clk_sat_lim;
			b_code_s[0] <= code_s6;
			b_rem_s[0]  <= num_s6;
			b_q_s[0]    <= '0;
			for (int k = 0; k < BN; k++) begin
				b_zero_s[k+1] <= b_zero_s[k];
				b_sat_s[k+1]  <= b_sat_s[k];
				b_code_s[k+1] <= b_code_s[k];
				if ({5'h00, b_rem_s[k]} >=
						({16'h0000, clk_hz_q} << (BN-1-k))) begin
					b_rem_s[k+1] <= b_rem_s[k] -
						dtfc_pkg::NUM_W'({16'h0000, clk_hz_q} << (BN-1-k));
					b_q_s[k+1]   <= {b_q_s[k][BN-2:0], 1'b1};
				end else begin
					b_rem_s[k+1] <= b_rem_s[k];
					b_q_s[k+1]   <= {b_q_s[k][BN-2:0], 1'b0};
				end
			end

			dtg_code <= b_code_s[BN];
			if (b_zero_s[BN]) begin
				actual_dead_time_ns <= '0;
			end else if (b_sat_s[BN]) begin
				actual_dead_time_ns <= dtfc_pkg::NS_MAX;
			end else begin
				actual_dead_time_ns <= b_q_s[BN];
			end
		end
	end

`ifndef NO_ASSERTIONS
	// A stalled pipeline keeps its output item.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(dtg_code)
			&& $stable(actual_dead_time_ns))
		else $error("output item changed while stalled");

	// Input is taken exactly when the pipeline advances.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow the pipeline advance");

	// Saturated tick counts always encode to the top code.
	a_top: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s4 && sat_s4 |=> code_s5 == dtfc_pkg::CODE_MAX)
		else $error("saturated ticks not clamped");

	// An item leaving the decode stage enters the nanosecond divider.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s6 |=> b_v_s[0])
		else $error("valid bit lost between stages");
`endif

endmodule

FILE: verif/dead_time_field_codec_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dead_time_field_codec_test
// The test reconverts every requested dead time with its own model of the
// codec and compares each returned code and actual dead time in order. It
// covers several timer clocks, the extremes among them, and random stalls on
// both the input and the output side.
// ----------------------------------------------------------------------------
module dead_time_field_codec_test;

	// Field code prefixes of the piecewise dead-time encoding.
	localparam logic [7:0] PFX_STEP2  = 8'h80;
	localparam logic [7:0] PFX_STEP8  = 8'hC0;
	localparam logic [7:0] PFX_STEP16 = 8'hE0;
	localparam int         LATENCY    = 23;

	typedef struct packed {
		logic [dtfc_pkg::CODE_W-1:0] code;
		logic [dtfc_pkg::NS_W-1:0]   ns;
	} dt_result_t;

	class dt_scoreboard;
		dt_result_t pending[$];
		logic [dtfc_pkg::CLK_W-1:0] clk_hz;
		int mismatches;
		int results_seen;

		function new();
			clk_hz = dtfc_pkg::CLK_RESET;
			mismatches = 0;
			results_seen = 0;
		endfunction

		function dt_result_t convert(logic [dtfc_pkg::NS_W-1:0] ns);
			dt_result_t r;
			longint unsigned ticks;
			longint unsigned q;
			longint unsigned dticks;
			longint unsigned act;
			ticks = (longint'(ns) * longint'(clk_hz) + 64'd500000000) / 64'd1000000000;
			if (ticks <= 127) begin
				r.code = ticks[7:0];
			end else if (ticks <= 255) begin
				r.code = PFX_STEP2 | 8'((ticks - 128) / 2);
			end else if (ticks <= 511) begin
				q = (ticks - 256) / 8;
				r.code = PFX_STEP8 | 8'(q > 31 ? 31 : q);
			end else begin
				q = (ticks - 512) / 16;
				r.code = PFX_STEP16 | 8'(q > 31 ? 31 : q);
			end
			if (!r.code[7]) begin
				dticks = 64'(r.code);
			end else if (!r.code[6]) begin
				dticks = 64'((64 + r.code[5:0]) * 2);
			end else if (!r.code[5]) begin
				dticks = 64'((32 + r.code[4:0]) * 8);
			end else begin
				dticks = 64'((32 + r.code[4:0]) * 16);
			end
			act = 64'd0;
			if (clk_hz != 0) begin
				act = (dticks * 64'd1000000000 + clk_hz / 2) / clk_hz;
				if (act > 64'd65535)
					act = 64'd65535;
			end
			r.ns = act[15:0];
			return r;
		endfunction

		function void note_request(logic [dtfc_pkg::NS_W-1:0] ns);
			pending.push_back(convert(ns));
		endfunction

		function void check_result(logic [dtfc_pkg::CODE_W-1:0] code,
				logic [dtfc_pkg::NS_W-1:0] ns);
			dt_result_t e;
			results_seen++;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: code %h ns %0d", code, ns);
				return;
			end
			e = pending.pop_front();
			if (e.code !== code || e.ns !== ns) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch: expected code %h ns %0d, got code %h ns %0d",
						e.code, e.ns, code, ns);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [dtfc_pkg::CLK_W-1:0] timer_clock_hz = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [dtfc_pkg::NS_W-1:0] request_ns = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [dtfc_pkg::CODE_W-1:0] dtg_code;
	logic [dtfc_pkg::NS_W-1:0] actual_dead_time_ns;

	dt_scoreboard sb = new();
	int clocks_written = 0;
	bit stall_free = 1'b0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	dead_time_field_codec dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .timer_clock_hz(timer_clock_hz),
		.in_valid(in_valid), .in_ready(in_ready), .request_ns(request_ns),
		.out_valid(out_valid), .out_ready(out_ready),
		.dtg_code(dtg_code), .actual_dead_time_ns(actual_dead_time_ns)
	);

	function automatic int gap_len();
		if (stall_free)
			return 0;
		if ($urandom_range(0, 19) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(0, 9) < 6 ? 0 : $urandom_range(1, 3);
	endfunction

	// Output side: random stalls, checking on every accepted item.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				sb.check_result(dtg_code, actual_dead_time_ns);
			out_ready <= (gap_len() == 0);
		end
	end

	// Valid stays high across back-to-back items; it drops only for a gap or a drain.
	task automatic send_request(logic [dtfc_pkg::NS_W-1:0] ns);
		int g;
		g = gap_len();
		if (g != 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		request_ns <= ns;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_request(ns);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic write_clock(logic [dtfc_pkg::CLK_W-1:0] hz);
		drain();
		cfg_valid <= 1'b1;
		timer_clock_hz <= hz;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		sb.clk_hz = hz;
		clocks_written++;
	endtask

	// Requests near the range boundaries for the current clock, in ns.
	task automatic boundary_sweep();
		longint unsigned t;
		int k;
		int edges[10] = '{0, 127, 128, 254, 255, 256, 504, 511, 1008, 1024};
		for (k = 0; k < 10; k++) begin
			if (sb.clk_hz != 0) begin
				t = (longint'(edges[k]) * 64'd1000000000) / sb.clk_hz;
				send_request(t > 65535 ? 16'hFFFF : t[15:0]);
			end
		end
	endtask

	task automatic random_phase(int n);
		int i;
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0)
				send_request(16'($urandom()));
			else
				send_request(16'($urandom_range(0, 7000)));
		end
	endtask

	initial begin
		int p;
		logic [dtfc_pkg::CLK_W-1:0] hz;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// Reset clock first, with field extremes and alternating bit patterns.
		send_request(16'h0000);
		send_request(16'hFFFF);
		send_request(16'h5555);
		send_request(16'hAAAA);
		boundary_sweep();
		write_clock('0);
		send_request(16'hFFFF);
		send_request(16'd1);
		write_clock('1);
		send_request(16'd1);
		send_request(16'hFFFF);
		boundary_sweep();
		write_clock(29'd1000000);
		send_request(16'hFFFF);
		boundary_sweep();
		write_clock(29'd500000000);
		random_phase(100);
		stall_free = 1'b1;
		random_phase(60);
		stall_free = 1'b0;
		for (p = 0; p < 5; p++) begin
			hz = $urandom_range(1000000, 500000000);
			write_clock(hz);
			boundary_sweep();
			random_phase(120);
		end
		drain();
		$display("Covered %0d results over %0d timer clock settings.",
			sb.results_seen, clocks_written + 1);
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#20ms;
		$display("== FAIL ==");
		$finish;
	end
endmodule
